@@ hdl/i4i6_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i4i6_pkg
// Shared types, codes and the pointer remap for the ICMPv4 to ICMPv6 header
// translator.
// ----------------------------------------------------------------------------
package i4i6_pkg;

    localparam int PLATEAU_WORDS = 3;
    localparam int PLATEAUS_PER_WORD = 4;

    typedef logic [PLATEAU_WORDS-1:0][63:0] plateau_bank_t;

    typedef struct packed {
        logic        found;
        logic [15:0] value;
    } plateau_hit_t;

    // outcome codes
    localparam logic [2:0] OC_OK          = 3'd0;
    localparam logic [2:0] OC_BAD_UNREACH = 3'd1;
    localparam logic [2:0] OC_BAD_POINTER = 3'd2;
    localparam logic [2:0] OC_BAD_PARAM   = 3'd3;
    localparam logic [2:0] OC_BAD_TYPE    = 3'd4;

    // configuration register indexes
    localparam logic [2:0] REG_NAT64_MODE      = 3'd0;
    localparam logic [2:0] REG_PLATEAU_COUNT   = 3'd1;
    localparam logic [2:0] REG_PLATEAUS_FIRST  = 3'd2;
    localparam logic [2:0] REG_PLATEAUS_SECOND = 3'd3;
    localparam logic [2:0] REG_PLATEAUS_THIRD  = 3'd4;

    // ICMPv4 types
    localparam logic [7:0] V4_ECHO_REPLY   = 8'd0;
    localparam logic [7:0] V4_DEST_UNREACH = 8'd3;
    localparam logic [7:0] V4_ECHO_REQUEST = 8'd8;
    localparam logic [7:0] V4_TIME_EXCEED  = 8'd11;
    localparam logic [7:0] V4_PARAM_PROB   = 8'd12;

    // ICMPv6 types
    localparam logic [7:0] V6_DEST_UNREACH = 8'd1;
    localparam logic [7:0] V6_PKT_TOO_BIG  = 8'd2;
    localparam logic [7:0] V6_TIME_EXCEED  = 8'd3;
    localparam logic [7:0] V6_PARAM_PROB   = 8'd4;
    localparam logic [7:0] V6_ECHO_REQUEST = 8'd128;
    localparam logic [7:0] V6_ECHO_REPLY   = 8'd129;

    localparam logic [7:0]  NO_FIELD        = 8'd255;
    localparam logic [7:0]  PTR_LIMIT       = 8'd19;
    localparam logic [31:0] NOROUTE_POINTER = 32'd6;
    localparam logic [16:0] MTU_HDR_DELTA   = 17'd20;
    localparam logic [28:0] MIN_MTU6        = 29'd1280;

    function automatic logic [7:0] ptr_map(input logic [4:0] idx);
        logic [7:0] res;
        case (idx)
            5'd0:                    res = 8'd0;
            5'd1:                    res = 8'd1;
            5'd2, 5'd3:              res = 8'd4;
            5'd8:                    res = 8'd7;
            5'd9:                    res = 8'd6;
            5'd12, 5'd13, 5'd14, 5'd15: res = 8'd8;
            5'd16, 5'd17, 5'd18, 5'd19: res = 8'd24;
            default:                 res = NO_FIELD;
        endcase
        return res;
    endfunction

endpackage

@@ hdl/i4i6_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i4i6 channel interfaces
// Valid/ready channels for headers in, translated headers out and register
// writes.
// ----------------------------------------------------------------------------
interface i4i6_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  icmp4_type;
    logic [7:0]  icmp4_code;
    logic [31:0] icmp4_rest;
    logic [15:0] nat64_echo_id;
    logic [15:0] inner_total_length;
    logic [27:0] ipv6_device_mtu;
    logic [27:0] ipv4_device_mtu;

    modport source (
        output valid, icmp4_type, icmp4_code, icmp4_rest, nat64_echo_id,
               inner_total_length, ipv6_device_mtu, ipv4_device_mtu,
        input  ready
    );
    modport sink (
        input  valid, icmp4_type, icmp4_code, icmp4_rest, nat64_echo_id,
               inner_total_length, ipv6_device_mtu, ipv4_device_mtu,
        output ready
    );
endinterface

interface i4i6_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  hdr6_type;
    logic [7:0]  hdr6_code;
    logic [31:0] icmp6_rest;
    logic [2:0]  outcome;

    modport source (
        output valid, hdr6_type, hdr6_code, icmp6_rest, outcome,
        input  ready
    );
    modport sink (
        input  valid, hdr6_type, hdr6_code, icmp6_rest, outcome,
        output ready
    );
endinterface

interface i4i6_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ hdl/i4i6_plateau_search.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i4i6_plateau_search
// Finds the first configured MTU plateau below the inner total length, with
// one comparator per slot and a one-hot first-hit select.
// ----------------------------------------------------------------------------
module i4i6_plateau_search #(
    parameter int SLOTS = 12
) (
    input  i4i6_pkg::plateau_bank_t plateaus,
    input  logic [3:0]              plateau_count,
    input  logic [15:0]             tot_len,
    output i4i6_pkg::plateau_hit_t  hit
);
    import i4i6_pkg::*;

    localparam logic [3:0] SLOTS_W = 4'(SLOTS);

    logic [3:0]       used;
    logic [SLOTS-1:0] match;
    logic [SLOTS-1:0] first;
    logic [15:0]      value [SLOTS];

    assign used = (plateau_count > SLOTS_W) ? SLOTS_W : plateau_count;

    for (genvar i = 0; i < SLOTS; i++) begin : g_slot
        assign value[i] = plateaus[i / PLATEAUS_PER_WORD]
                                  [(i % PLATEAUS_PER_WORD) * 16 +: 16];
        assign match[i] = (4'(i) < used) && (value[i] < tot_len);
    end

    assign first = match & (~match + SLOTS'(1));

    always_comb
    begin
        hit.found = |match;
        hit.value = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            hit.value = hit.value | (value[i] & {16{first[i]}});
        end
    end

endmodule

@@ hdl/icmp4_to_icmp6_header_translate.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icmp4_to_icmp6_header_translate
// Translates one ICMPv4 header into an ICMPv6 header or a drop outcome.
// ----------------------------------------------------------------------------
// Usage:
//   in_item  : ICMPv4 type, code, rest word, NAT64 echo id, inner total
//              length and both device MTUs; one transaction per header.
//   out_item : ICMPv6 type, code, rest word and outcome; one transaction per
//              input transaction, in order. Dropped headers carry zero fields.
//   cfg      : register writes (index, data), always ready; write only while
//              no transaction is in flight.
// One header per cycle is sustained while out_item is ready. The three stages
// are decode with the plateau comparators, MTU clamp against the IPv6 device
// MTU, and clamp against the IPv4 device MTU with the 1280 floor, whose
// register drives the output.
// Reset clears all stage valids and the configuration registers, not the stage
// data registers. When out_item stalls, each stage keeps its transaction and
// the earlier stages fill up before in_item drops ready.
// ----------------------------------------------------------------------------
module icmp4_to_icmp6_header_translate #(
    parameter int PLATEAU_SLOTS = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    i4i6_in_if.sink     in_item,
    i4i6_out_if.source  out_item,
    i4i6_cfg_if.sink    cfg
);
    import i4i6_pkg::*;

    // configuration
    logic          nat64_mode_reg;
    logic [3:0]    plateau_count_reg;
    plateau_bank_t plateaus_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nat64_mode_reg    <= 1'b0;
            plateau_count_reg <= '0;
            plateaus_reg      <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_NAT64_MODE:      nat64_mode_reg    <= cfg.data[0];
                REG_PLATEAU_COUNT:   plateau_count_reg <= cfg.data[3:0];
                REG_PLATEAUS_FIRST:  plateaus_reg[0]   <= cfg.data;
                REG_PLATEAUS_SECOND: plateaus_reg[1]   <= cfg.data;
                REG_PLATEAUS_THIRD:  plateaus_reg[2]   <= cfg.data;
                default: ;
            endcase
        end
    end

    // stage handshake
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic s1_ready, s2_ready, s3_ready;

    assign s3_ready      = !s3_valid_reg || out_item.ready;
    assign s2_ready      = !s2_valid_reg || s3_ready;
    assign s1_ready      = !s1_valid_reg || s2_ready;
    assign in_item.ready = s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= in_item.valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
            if (s3_ready)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    // stage 1: decode and plateau search
    plateau_hit_t hit;
    logic [7:0]   s1_type_next, s1_code_next, ptr, ptr_val;
    logic [31:0]  s1_rest_next;
    logic [2:0]   s1_oc_next;
    logic         s1_ptb_next;
    logic [15:0]  s1_pm_next;

    i4i6_plateau_search #(
        .SLOTS (PLATEAU_SLOTS)
    ) u_search (
        .plateaus      (plateaus_reg),
        .plateau_count (plateau_count_reg),
        .tot_len       (in_item.inner_total_length),
        .hit           (hit)
    );

    assign ptr     = in_item.icmp4_rest[31:24];
    assign ptr_val = ptr_map(ptr[4:0]);

    always_comb
    begin
        s1_type_next = '0;
        s1_code_next = '0;
        s1_rest_next = '0;
        s1_oc_next   = OC_OK;
        s1_ptb_next  = 1'b0;
        if (in_item.icmp4_rest[15:0] != 16'd0)
            s1_pm_next = in_item.icmp4_rest[15:0];
        else
            s1_pm_next = hit.found ? hit.value : 16'd0;

        case (in_item.icmp4_type)
            V4_ECHO_REQUEST, V4_ECHO_REPLY:
            begin
                s1_type_next = (in_item.icmp4_type == V4_ECHO_REQUEST) ?
                               V6_ECHO_REQUEST : V6_ECHO_REPLY;
                s1_rest_next = nat64_mode_reg ?
                               {in_item.nat64_echo_id, in_item.icmp4_rest[15:0]} :
                               in_item.icmp4_rest;
            end
            V4_DEST_UNREACH:
            begin
                case (in_item.icmp4_code)
                    8'd0, 8'd1, 8'd5, 8'd6, 8'd7, 8'd8, 8'd11, 8'd12:
                        s1_type_next = V6_DEST_UNREACH;
                    8'd2:
                    begin
                        s1_type_next = V6_PARAM_PROB;
                        s1_code_next = 8'd1;
                        s1_rest_next = NOROUTE_POINTER;
                    end
                    8'd3:
                    begin
                        s1_type_next = V6_DEST_UNREACH;
                        s1_code_next = 8'd4;
                    end
                    8'd4:
                    begin
                        s1_type_next = V6_PKT_TOO_BIG;
                        s1_ptb_next  = 1'b1;
                    end
                    8'd9, 8'd10, 8'd13, 8'd15:
                    begin
                        s1_type_next = V6_DEST_UNREACH;
                        s1_code_next = 8'd1;
                    end
                    default: s1_oc_next = OC_BAD_UNREACH;
                endcase
            end
            V4_TIME_EXCEED:
            begin
                s1_type_next = V6_TIME_EXCEED;
                s1_code_next = in_item.icmp4_code;
            end
            V4_PARAM_PROB:
            begin
                if (in_item.icmp4_code == 8'd0 || in_item.icmp4_code == 8'd2)
                begin
                    if (ptr > PTR_LIMIT || ptr_val == NO_FIELD)
                        s1_oc_next = OC_BAD_POINTER;
                    else
                    begin
                        s1_type_next = V6_PARAM_PROB;
                        s1_rest_next = {24'd0, ptr_val};
                    end
                end
                else
                    s1_oc_next = OC_BAD_PARAM;
            end
            default: s1_oc_next = OC_BAD_TYPE;
        endcase
    end

    logic [7:0]  s1_type_reg, s1_code_reg;
    logic [31:0] s1_rest_reg;
    logic [2:0]  s1_oc_reg;
    logic        s1_ptb_reg;
    logic [15:0] s1_pm_reg;
    logic [27:0] s1_v6_reg;
    logic [28:0] s1_v4p_reg;

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_item.valid)
        begin
            s1_type_reg <= s1_type_next;
            s1_code_reg <= s1_code_next;
            s1_rest_reg <= s1_rest_next;
            s1_oc_reg   <= s1_oc_next;
            s1_ptb_reg  <= s1_ptb_next;
            s1_pm_reg   <= s1_pm_next;
            s1_v6_reg   <= in_item.ipv6_device_mtu;
            s1_v4p_reg  <= {1'b0, in_item.ipv4_device_mtu} + 29'(MTU_HDR_DELTA);
        end
    end

    // stage 2: min against the IPv6 device MTU
    logic [16:0] pm_plus;
    logic [27:0] s2_mtu_next;

    assign pm_plus     = {1'b0, s1_pm_reg} + MTU_HDR_DELTA;
    assign s2_mtu_next = (s1_v6_reg < 28'(pm_plus)) ? s1_v6_reg : 28'(pm_plus);

    logic [7:0]  s2_type_reg, s2_code_reg;
    logic [31:0] s2_rest_reg;
    logic [2:0]  s2_oc_reg;
    logic        s2_ptb_reg;
    logic [27:0] s2_mtu_reg;
    logic [28:0] s2_v4p_reg;

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_type_reg <= s1_type_reg;
            s2_code_reg <= s1_code_reg;
            s2_rest_reg <= s1_rest_reg;
            s2_oc_reg   <= s1_oc_reg;
            s2_ptb_reg  <= s1_ptb_reg;
            s2_mtu_reg  <= s2_mtu_next;
            s2_v4p_reg  <= s1_v4p_reg;
        end
    end

    // stage 3: min against the IPv4 device MTU, floor, output register
    logic [28:0] mtu_min, mtu_final;

    assign mtu_min   = (s2_v4p_reg < {1'b0, s2_mtu_reg}) ? s2_v4p_reg :
                       {1'b0, s2_mtu_reg};
    assign mtu_final = (mtu_min < MIN_MTU6) ? MIN_MTU6 : mtu_min;

    logic [7:0]  s3_type_reg, s3_code_reg;
    logic [31:0] s3_rest_reg;
    logic [2:0]  s3_oc_reg;

    always_ff @(posedge clk)
    begin
        if (s3_ready && s2_valid_reg)
        begin
            s3_type_reg <= s2_type_reg;
            s3_code_reg <= s2_code_reg;
            s3_rest_reg <= s2_ptb_reg ? {3'd0, mtu_final} : s2_rest_reg;
            s3_oc_reg   <= s2_oc_reg;
        end
    end

    assign out_item.valid      = s3_valid_reg;
    assign out_item.hdr6_type  = s3_type_reg;
    assign out_item.hdr6_code  = s3_code_reg;
    assign out_item.icmp6_rest = s3_rest_reg;
    assign out_item.outcome    = s3_oc_reg;

    // checks
    a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && s3_oc_reg != OC_OK) |->
        (s3_type_reg == 8'd0 && s3_code_reg == 8'd0 && s3_rest_reg == 32'd0))
        else $error("drop outcome with non-zero header fields");

    a_ptb_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && s3_oc_reg == OC_OK && s3_type_reg == V6_PKT_TOO_BIG) |->
        (s3_rest_reg >= 32'(MIN_MTU6)))
        else $error("packet too big MTU below IPv6 minimum");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_item.ready |-> (s1_valid_reg && s2_valid_reg && s3_valid_reg
                            && !out_item.ready))
        else $error("input stalled while pipeline has room");

    a_echo_code: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && (s3_type_reg == V6_ECHO_REQUEST ||
                          s3_type_reg == V6_ECHO_REPLY)) |->
        (s3_code_reg == 8'd0 && s3_oc_reg == OC_OK))
        else $error("echo translated with non-zero code");

endmodule

@@ tb/sv/icmp4_to_icmp6_header_translate_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icmp4_to_icmp6_header_translate_test
// Self-checking bench for the ICMPv4 to ICMPv6 header translator. A short
// table covers echo, every Destination Unreachable mapping, Packet Too Big
// clamping, Time Exceeded and Parameter Problem pointers, partly with typed
// results. Random headers then run under several register settings with
// idling on both channels. Each result is checked against a predictor.
// ----------------------------------------------------------------------------
module icmp4_to_icmp6_header_translate_test;
    import i4i6_pkg::*;

    localparam int PLATEAU_SLOTS   = 12;
    localparam int DIR_ROWS        = 26;
    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 300;
    localparam int LIMIT_CYCLES    = 500000;

    localparam logic [2:0] REG_UNUSED = 3'd7;

    // ICMPv4 codes
    localparam logic [7:0] UNR4_NET       = 8'd0;
    localparam logic [7:0] UNR4_PROTO     = 8'd2;
    localparam logic [7:0] UNR4_PORT      = 8'd3;
    localparam logic [7:0] UNR4_FRAG      = 8'd4;
    localparam logic [7:0] UNR4_FIRST_BAD = 8'd14;
    localparam logic [7:0] UNR4_CUTOFF    = 8'd15;
    localparam logic [7:0] TE4_TTL        = 8'd0;
    localparam logic [7:0] PP4_POINTER    = 8'd0;
    localparam logic [7:0] PP4_MISS_OPT   = 8'd1;
    localparam logic [7:0] PP4_BAD_LEN    = 8'd2;
    localparam logic [7:0] CODE_MAX       = 8'hff;
    localparam logic [7:0] TYPE_MAX       = 8'hff;

    // ICMPv6 codes
    localparam logic [7:0] C6_PLAIN    = 8'd0;
    localparam logic [7:0] C6_NOROUTE  = 8'd0;
    localparam logic [7:0] C6_ADMIN    = 8'd1;
    localparam logic [7:0] C6_PORT     = 8'd4;
    localparam logic [7:0] C6_HDR_FLD  = 8'd0;
    localparam logic [7:0] C6_NEXT_HDR = 8'd1;

    // unreachable codes folded into no-route / admin-prohibited
    localparam logic [15:0] UNR_TO_NOROUTE = 16'h19e3;
    localparam logic [15:0] UNR_TO_ADMIN   = 16'ha600;

    localparam logic [27:0] MTU_ALL = 28'hfff_ffff;

    localparam logic [7:0] PTR_REMAP [20] = '{
        8'd0, 8'd1, 8'd4, 8'd4,
        NO_FIELD, NO_FIELD, NO_FIELD, NO_FIELD,
        8'd7, 8'd6, NO_FIELD, NO_FIELD,
        8'd8, 8'd8, 8'd8, 8'd8,
        8'd24, 8'd24, 8'd24, 8'd24
    };

    typedef struct packed {
        logic [7:0]  icmp4_type;
        logic [7:0]  icmp4_code;
        logic [31:0] icmp4_rest;
        logic [15:0] echo_id;
        logic [15:0] tot_len;
        logic [27:0] v6_mtu;
        logic [27:0] v4_mtu;
    } hdr_t;

    typedef struct packed {
        logic [7:0]  hdr6_type;
        logic [7:0]  hdr6_code;
        logic [31:0] icmp6_rest;
        logic [2:0]  outcome;
    } xlat_t;

    typedef struct packed {
        logic  stage;
        hdr_t  hdr;
        logic  typed;
        xlat_t want;
    } dir_row_t;

    localparam xlat_t XL_NONE = '0;

    logic clk;
    logic rst_n;

    i4i6_in_if  hdr_in ();
    i4i6_out_if hdr_out ();
    i4i6_cfg_if reg_wr ();

    icmp4_to_icmp6_header_translate i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (hdr_in),
        .out_item (hdr_out),
        .cfg      (reg_wr)
    );

    logic          mode_nat64;
    logic [3:0]    plateau_cnt;
    plateau_bank_t plateau_bank;

    xlat_t    pending_xlat [$];
    xlat_t    got_want;
    dir_row_t dir_tab [DIR_ROWS];

    int in_mode;
    int out_mode;
    int fail_cnt;
    int n_sent;
    int n_checked;
    int n_drops;
    int n_ptb;
    int n_settings;
    int cycle_cnt;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic logic [15:0] plateau_of(int idx);
        return plateau_bank[idx / 4][(idx % 4) * 16 +: 16];
    endfunction

    function automatic logic [31:0] ptb_mtu(hdr_t h);
        logic [31:0] mtu;
        logic [15:0] p;
        int          n;
        logic        hit;
        mtu = {16'd0, h.icmp4_rest[15:0]};
        n   = (plateau_cnt > PLATEAU_SLOTS) ? PLATEAU_SLOTS : plateau_cnt;
        hit = 1'b0;
        if (mtu == 32'd0)
        begin
            for (int i = 0; i < n; i++)
            begin
                p = plateau_of(i);
                if (!hit && p < h.tot_len)
                begin
                    mtu = {16'd0, p};
                    hit = 1'b1;
                end
            end
        end
        mtu = mtu + MTU_HDR_DELTA;
        if ({4'd0, h.v6_mtu} < mtu)
            mtu = {4'd0, h.v6_mtu};
        if ({4'd0, h.v4_mtu} + MTU_HDR_DELTA < mtu)
            mtu = {4'd0, h.v4_mtu} + MTU_HDR_DELTA;
        if (mtu < MIN_MTU6)
            mtu = MIN_MTU6;
        return mtu;
    endfunction

    function automatic xlat_t translate_header(hdr_t h);
        xlat_t      x;
        logic [7:0] ptr;
        x = XL_NONE;
        x.outcome = OC_OK;
        case (h.icmp4_type)
            V4_ECHO_REQUEST, V4_ECHO_REPLY:
            begin
                x.hdr6_type = (h.icmp4_type == V4_ECHO_REQUEST) ? V6_ECHO_REQUEST
                                                                : V6_ECHO_REPLY;
                x.hdr6_code = C6_PLAIN;
                x.icmp6_rest = mode_nat64 ? {h.echo_id, h.icmp4_rest[15:0]} : h.icmp4_rest;
            end
            V4_DEST_UNREACH:
            begin
                x.hdr6_type = V6_DEST_UNREACH;
                if (h.icmp4_code == UNR4_PROTO)
                begin
                    x.hdr6_type  = V6_PARAM_PROB;
                    x.hdr6_code  = C6_NEXT_HDR;
                    x.icmp6_rest = NOROUTE_POINTER;
                end
                else if (h.icmp4_code == UNR4_PORT)
                    x.hdr6_code = C6_PORT;
                else if (h.icmp4_code == UNR4_FRAG)
                begin
                    x.hdr6_type  = V6_PKT_TOO_BIG;
                    x.hdr6_code  = C6_PLAIN;
                    x.icmp6_rest = ptb_mtu(h);
                end
                else if (h.icmp4_code < 8'd16 && UNR_TO_NOROUTE[h.icmp4_code[3:0]])
                    x.hdr6_code = C6_NOROUTE;
                else if (h.icmp4_code < 8'd16 && UNR_TO_ADMIN[h.icmp4_code[3:0]])
                    x.hdr6_code = C6_ADMIN;
                else
                    x.outcome = OC_BAD_UNREACH;
            end
            V4_TIME_EXCEED:
            begin
                x.hdr6_type = V6_TIME_EXCEED;
                x.hdr6_code = h.icmp4_code;
            end
            V4_PARAM_PROB:
            begin
                ptr = h.icmp4_rest[31:24];
                if (h.icmp4_code != PP4_POINTER && h.icmp4_code != PP4_BAD_LEN)
                    x.outcome = OC_BAD_PARAM;
                else if (ptr > PTR_LIMIT || PTR_REMAP[ptr] == NO_FIELD)
                    x.outcome = OC_BAD_POINTER;
                else
                begin
                    x.hdr6_type  = V6_PARAM_PROB;
                    x.hdr6_code  = C6_HDR_FLD;
                    x.icmp6_rest = {24'd0, PTR_REMAP[ptr]};
                end
            end
            default:
                x.outcome = OC_BAD_TYPE;
        endcase
        if (x.outcome != OC_OK)
            x = '{8'd0, 8'd0, 32'd0, x.outcome};
        return x;
    endfunction

    function automatic int pick_gap(int mode);
        int r;
        r = $urandom_range(0, 99);
        if (mode == 0)
            return 0;
        if (mode == 1)
            return (r < 75) ? 0 : (r < 97) ? $urandom_range(1, 3) : $urandom_range(8, 30);
        return (r < 40) ? 0 : (r < 85) ? $urandom_range(1, 4) : $urandom_range(10, 40);
    endfunction

    function automatic logic [27:0] rand_mtu();
        int k;
        k = $urandom_range(0, 9);
        case (k)
            0:       return 28'd0;
            1:       return MTU_ALL;
            2, 3:    return 28'($urandom);
            4:       return 28'($urandom_range(0, 1300));
            5, 6, 7: return 28'($urandom_range(1200, 9200));
            default: return 28'($urandom_range(1240, 1320));
        endcase
    endfunction

    function automatic hdr_t rand_header();
        hdr_t h;
        int   sel;
        int   k;
        h.icmp4_type = V4_DEST_UNREACH;
        h.icmp4_code = 8'($urandom);
        h.icmp4_rest = $urandom;
        h.echo_id    = 16'($urandom);
        h.tot_len    = 16'($urandom);
        h.v6_mtu     = rand_mtu();
        h.v4_mtu     = rand_mtu();
        sel = $urandom_range(0, 99);
        if (sel < 12)
            h.icmp4_type = $urandom_range(0, 1) ? V4_ECHO_REQUEST : V4_ECHO_REPLY;
        else if (sel < 38)
        begin
            if ($urandom_range(0, 4) != 0)
                h.icmp4_code = 8'($urandom_range(0, 15));
        end
        else if (sel < 62)
        begin
            h.icmp4_code = UNR4_FRAG;
            if ($urandom_range(0, 1) != 0)
                h.icmp4_rest[15:0] = 16'd0;
            k = $urandom_range(0, 3);
            if (k == 0)
                h.tot_len = plateau_of($urandom_range(0, PLATEAU_SLOTS - 1))
                            + 16'($urandom_range(0, 2)) - 16'd1;
            else if (k == 1)
                h.tot_len = 16'($urandom_range(0, 2000));
        end
        else if (sel < 74)
        begin
            h.icmp4_type = V4_TIME_EXCEED;
            if ($urandom_range(0, 1) != 0)
                h.icmp4_code = 8'($urandom_range(0, 1));
        end
        else if (sel < 92)
        begin
            h.icmp4_type = V4_PARAM_PROB;
            if ($urandom_range(0, 9) < 7)
                h.icmp4_code = $urandom_range(0, 1) ? PP4_POINTER : PP4_BAD_LEN;
            if ($urandom_range(0, 4) != 0)
                h.icmp4_rest[31:24] = 8'($urandom_range(0, 19));
        end
        else
            h.icmp4_type = 8'($urandom);
        return h;
    endfunction

    task automatic send_hdr(hdr_t h, xlat_t want);
        hdr_in.valid              <= 1'b1;
        hdr_in.icmp4_type         <= h.icmp4_type;
        hdr_in.icmp4_code         <= h.icmp4_code;
        hdr_in.icmp4_rest         <= h.icmp4_rest;
        hdr_in.nat64_echo_id      <= h.echo_id;
        hdr_in.inner_total_length <= h.tot_len;
        hdr_in.ipv6_device_mtu    <= h.v6_mtu;
        hdr_in.ipv4_device_mtu    <= h.v4_mtu;
        @(posedge clk);
        while (!hdr_in.ready)
            @(posedge clk);
        pending_xlat.push_back(want);
        n_sent++;
    endtask

    task automatic idle_in(int cycles);
        hdr_in.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic drain();
        while (pending_xlat.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] data);
        reg_wr.valid <= 1'b1;
        reg_wr.index <= idx;
        reg_wr.data  <= data;
        @(posedge clk);
        while (!reg_wr.ready)
            @(posedge clk);
        case (idx)
            REG_NAT64_MODE:      mode_nat64      = data[0];
            REG_PLATEAU_COUNT:   plateau_cnt     = data[3:0];
            REG_PLATEAUS_FIRST:  plateau_bank[0] = data;
            REG_PLATEAUS_SECOND: plateau_bank[1] = data;
            REG_PLATEAUS_THIRD:  plateau_bank[2] = data;
            default: ;
        endcase
    endtask

    task automatic set_regs(logic nat, logic [3:0] cnt, logic [63:0] w0, logic [63:0] w1,
                            logic [63:0] w2, logic poke_unused);
        write_reg(REG_NAT64_MODE, {$urandom, 31'($urandom), nat});
        write_reg(REG_PLATEAU_COUNT, {$urandom, 28'($urandom), cnt});
        write_reg(REG_PLATEAUS_FIRST, w0);
        write_reg(REG_PLATEAUS_SECOND, w1);
        write_reg(REG_PLATEAUS_THIRD, w2);
        if (poke_unused)
            write_reg(REG_UNUSED, {$urandom, $urandom});
        reg_wr.valid <= 1'b0;
        @(posedge clk);
        n_settings++;
    endtask

    // RFC 1191 style descending plateau list
    localparam logic [63:0] STD_W0 = {16'd8166, 16'd17914, 16'd32000, 16'd65535};
    localparam logic [63:0] STD_W1 = {16'd1006, 16'd1492, 16'd2002, 16'd4352};
    localparam logic [63:0] STD_W2 = {16'd0, 16'd68, 16'd296, 16'd508};

    // sink side stalls
    initial
    begin
        int  hold;
        logic rdy;
        hdr_out.ready <= 1'b0;
        hold = 0;
        rdy  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
                hold--;
            else if (out_mode == 0)
                rdy = 1'b1;
            else
            begin
                rdy  = ($urandom_range(0, 99) < 70);
                hold = rdy ? $urandom_range(0, 6) : pick_gap(out_mode);
            end
            hdr_out.ready <= rdy;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && hdr_out.valid && hdr_out.ready)
        begin
            if (pending_xlat.size() == 0)
            begin
                $error("translated header with no transaction outstanding");
                fail_cnt++;
            end
            else
            begin
                got_want = pending_xlat.pop_front();
                n_checked++;
                if (got_want.outcome != OC_OK)
                    n_drops++;
                if (got_want.hdr6_type == V6_PKT_TOO_BIG && got_want.outcome == OC_OK)
                    n_ptb++;
                if (hdr_out.hdr6_type !== got_want.hdr6_type)
                begin
                    $error("hdr6_type: expected %0d, got %0d",
                           got_want.hdr6_type, hdr_out.hdr6_type);
                    fail_cnt++;
                end
                if (hdr_out.hdr6_code !== got_want.hdr6_code)
                begin
                    $error("hdr6_code: expected %0d, got %0d",
                           got_want.hdr6_code, hdr_out.hdr6_code);
                    fail_cnt++;
                end
                if (hdr_out.icmp6_rest !== got_want.icmp6_rest)
                begin
                    $error("icmp6_rest: expected 0x%08h, got 0x%08h",
                           got_want.icmp6_rest, hdr_out.icmp6_rest);
                    fail_cnt++;
                end
                if (hdr_out.outcome !== got_want.outcome)
                begin
                    $error("outcome: expected %0d, got %0d",
                           got_want.outcome, hdr_out.outcome);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES)
        begin
            $display("icmp4_to_icmp6_header_translate_test failed");
            $finish;
        end
    end

    initial
    begin
        hdr_t  h;
        xlat_t w;
        logic  stage_now;
        int    gap;
        rst_n                      <= 1'b0;
        hdr_in.valid               <= 1'b0;
        hdr_in.icmp4_type          <= '0;
        hdr_in.icmp4_code          <= '0;
        hdr_in.icmp4_rest          <= '0;
        hdr_in.nat64_echo_id       <= '0;
        hdr_in.inner_total_length  <= '0;
        hdr_in.ipv6_device_mtu     <= '0;
        hdr_in.ipv4_device_mtu     <= '0;
        reg_wr.valid               <= 1'b0;
        reg_wr.index               <= '0;
        reg_wr.data                <= '0;
        mode_nat64   = 1'b0;
        plateau_cnt  = '0;
        plateau_bank = '0;
        in_mode      = 1;
        out_mode     = 1;
        fail_cnt     = 0;
        n_sent       = 0;
        n_checked    = 0;
        n_drops      = 0;
        n_ptb        = 0;
        n_settings   = 1;
        cycle_cnt    = 0;
        stage_now    = 1'b0;
        gap          = 0;

        dir_tab = '{
            '{1'b0, '{V4_ECHO_REQUEST, 8'h00, 32'hdead_beef, 16'h1111, 16'd0, 28'd0, 28'd0},
              1'b1, '{V6_ECHO_REQUEST, C6_PLAIN, 32'hdead_beef, OC_OK}},
            '{1'b0, '{V4_ECHO_REPLY, CODE_MAX, 32'hffff_ffff, 16'hffff, 16'hffff, MTU_ALL,
                      MTU_ALL},
              1'b1, '{V6_ECHO_REPLY, C6_PLAIN, 32'hffff_ffff, OC_OK}},
            '{1'b0, '{V4_DEST_UNREACH, UNR4_NET, 32'h1234_5678, 16'd0, 16'd0, 28'd0, 28'd0},
              1'b1, '{V6_DEST_UNREACH, C6_NOROUTE, 32'd0, OC_OK}},
            '{1'b0, '{V4_DEST_UNREACH, UNR4_PROTO, 32'hffff_ffff, 16'd0, 16'd0, 28'd0, 28'd0},
              1'b1, '{V6_PARAM_PROB, C6_NEXT_HDR, NOROUTE_POINTER, OC_OK}},
            '{1'b0, '{V4_DEST_UNREACH, UNR4_PORT, 32'h0, 16'd0, 16'd0, 28'd0, 28'd0},
              1'b1, '{V6_DEST_UNREACH, C6_PORT, 32'd0, OC_OK}},
            '{1'b0, '{V4_DEST_UNREACH, UNR4_CUTOFF, 32'h0, 16'd0, 16'd0, 28'd0, 28'd0},
              1'b1, '{V6_DEST_UNREACH, C6_ADMIN, 32'd0, OC_OK}},
            '{1'b0, '{V4_DEST_UNREACH, UNR4_FIRST_BAD, 32'h0, 16'd0, 16'd0, 28'd0, 28'd0},
              1'b1, '{8'd0, 8'd0, 32'd0, OC_BAD_UNREACH}},
            '{1'b0, '{V4_DEST_UNREACH, CODE_MAX, 32'h0, 16'd0, 16'd0, 28'd0, 28'd0},
              1'b1, '{8'd0, 8'd0, 32'd0, OC_BAD_UNREACH}},
            '{1'b0, '{V4_DEST_UNREACH, UNR4_FRAG, 32'h0, 16'd0, 16'd1500, MTU_ALL, MTU_ALL},
              1'b1, '{V6_PKT_TOO_BIG, C6_PLAIN, 32'd1280, OC_OK}},
            '{1'b0, '{V4_DEST_UNREACH, UNR4_FRAG, 32'h0000_ffff, 16'd0, 16'd0, MTU_ALL,
                      MTU_ALL},
              1'b1, '{V6_PKT_TOO_BIG, C6_PLAIN, 32'd65555, OC_OK}},
            '{1'b0, '{V4_DEST_UNREACH, UNR4_FRAG, 32'hffff_05dc, 16'd0, 16'd0, 28'd1400,
                      28'd9000},
              1'b1, '{V6_PKT_TOO_BIG, C6_PLAIN, 32'd1400, OC_OK}},
            '{1'b0, '{V4_DEST_UNREACH, UNR4_FRAG, 32'd9000, 16'd0, 16'd0, 28'd9999, 28'd1480},
              1'b1, '{V6_PKT_TOO_BIG, C6_PLAIN, 32'd1500, OC_OK}},
            '{1'b0, '{V4_DEST_UNREACH, UNR4_FRAG, 32'hffff_ffff, 16'd0, 16'hffff, 28'd0, 28'd0},
              1'b1, '{V6_PKT_TOO_BIG, C6_PLAIN, 32'd1280, OC_OK}},
            '{1'b0, '{V4_TIME_EXCEED, TE4_TTL, 32'h0, 16'd0, 16'd0, 28'd0, 28'd0},
              1'b1, '{V6_TIME_EXCEED, TE4_TTL, 32'd0, OC_OK}},
            '{1'b0, '{V4_TIME_EXCEED, CODE_MAX, 32'hffff_ffff, 16'd0, 16'd0, 28'd0, 28'd0},
              1'b1, '{V6_TIME_EXCEED, CODE_MAX, 32'd0, OC_OK}},
            '{1'b0, '{V4_PARAM_PROB, PP4_POINTER, 32'h00ff_ffff, 16'd0, 16'd0, 28'd0, 28'd0},
              1'b1, '{V6_PARAM_PROB, C6_HDR_FLD, 32'd0, OC_OK}},
            '{1'b0, '{V4_PARAM_PROB, PP4_BAD_LEN, 32'h1300_0000, 16'd0, 16'd0, 28'd0, 28'd0},
              1'b1, '{V6_PARAM_PROB, C6_HDR_FLD, 32'd24, OC_OK}},
            '{1'b0, '{V4_PARAM_PROB, PP4_POINTER, 32'h0400_0000, 16'd0, 16'd0, 28'd0, 28'd0},
              1'b1, '{8'd0, 8'd0, 32'd0, OC_BAD_POINTER}},
            '{1'b0, '{V4_PARAM_PROB, PP4_POINTER, 32'h1400_0000, 16'd0, 16'd0, 28'd0, 28'd0},
              1'b1, '{8'd0, 8'd0, 32'd0, OC_BAD_POINTER}},
            '{1'b0, '{V4_PARAM_PROB, PP4_BAD_LEN, 32'hff00_0000, 16'd0, 16'd0, 28'd0, 28'd0},
              1'b1, '{8'd0, 8'd0, 32'd0, OC_BAD_POINTER}},
            '{1'b0, '{V4_PARAM_PROB, PP4_MISS_OPT, 32'h0, 16'd0, 16'd0, 28'd0, 28'd0},
              1'b1, '{8'd0, 8'd0, 32'd0, OC_BAD_PARAM}},
            '{1'b0, '{TYPE_MAX, 8'h00, 32'h0, 16'd0, 16'd0, 28'd0, 28'd0},
              1'b1, '{8'd0, 8'd0, 32'd0, OC_BAD_TYPE}},
            '{1'b1, '{V4_ECHO_REQUEST, 8'h00, 32'h1234_5678, 16'habcd, 16'd0, 28'd0, 28'd0},
              1'b0, XL_NONE},
            '{1'b1, '{V4_DEST_UNREACH, UNR4_FRAG, 32'h0, 16'd0, 16'd1500, MTU_ALL, MTU_ALL},
              1'b0, XL_NONE},
            '{1'b1, '{V4_DEST_UNREACH, UNR4_FRAG, 32'h0, 16'd0, 16'hffff, 28'd40000, MTU_ALL},
              1'b0, XL_NONE},
            '{1'b1, '{V4_PARAM_PROB, PP4_POINTER, 32'h09ab_cdef, 16'd0, 16'd0, 28'd0, 28'd0},
              1'b0, XL_NONE}
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // table: reset settings first, then nat64 with an over-range count
        foreach (dir_tab[i])
        begin
            if (dir_tab[i].stage != stage_now)
            begin
                idle_in(1);
                drain();
                set_regs(1'b1, 4'd15, STD_W0, STD_W1, STD_W2, 1'b0);
                stage_now = dir_tab[i].stage;
            end
            w = dir_tab[i].typed ? dir_tab[i].want : translate_header(dir_tab[i].hdr);
            send_hdr(dir_tab[i].hdr, w);
            gap = pick_gap(in_mode);
            if (gap != 0)
                idle_in(gap);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            idle_in(1);
            drain();
            in_mode  = ph % 3;
            out_mode = (ph * 2) % 3;
            case (ph)
                0: set_regs(1'b0, 4'd12, STD_W0, STD_W1, STD_W2, 1'b0);
                1: set_regs(1'b1, 4'd0, {$urandom, $urandom}, {$urandom, $urandom},
                            {$urandom, $urandom}, 1'b0);
                2: set_regs(1'($urandom), 4'($urandom_range(1, 11)), {$urandom, $urandom},
                            {$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
                3: set_regs(1'b1, 4'd15, '1, '1, '1, 1'b1);
                4: set_regs(1'b0, 4'd12, '0, '0, '0, 1'b0);
                default: set_regs(1'($urandom), 4'd13, {$urandom, $urandom},
                                  {$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                h = rand_header();
                send_hdr(h, translate_header(h));
                gap = pick_gap(in_mode);
                if (ph == 2 && n == ITEMS_PER_PHASE / 2)
                begin
                    idle_in(1);
                    drain();
                end
                else if (gap != 0)
                    idle_in(gap);
            end
        end

        idle_in(1);
        drain();
        repeat (10) @(posedge clk);

        $display("%0d headers sent across %0d register settings, incl. nat64, clamped count",
                 n_sent, n_settings);
        $display("%0d results compared: %0d drops, %0d packet-too-big MTUs",
                 n_checked, n_drops, n_ptb);
        if (fail_cnt == 0)
            $display("icmp4_to_icmp6_header_translate_test passed");
        else
            $display("icmp4_to_icmp6_header_translate_test failed");
        $finish;
    end

endmodule
